FILE: rtl/core/g5r_pkg.sv
package g5r_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 480;

    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_CELLS = GLYPH_ROWS * GLYPH_COLS;

    // cursor advance in glyph cells per character
    localparam int ADVANCE_CELLS = 6;

    typedef struct packed {
        logic [7:0]  char_code;
        logic        restart;
        logic [15:0] start_x;
        logic [15:0] row_y;
        logic [15:0] color;
        logic [7:0]  scale;
    } in_req_t;

    typedef struct packed {
        logic [8:0]  rect_x;
        logic [8:0]  rect_y;
        logic [7:0]  rect_w;
        logic [7:0]  rect_h;
        logic [15:0] rect_color;
        logic        last;
    } out_req_t;

    // walker to emitter control
    typedef struct packed {
        logic sq_valid;
        logic flush;
    } walk_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_WALK,
        ST_DONE
    } walk_state_t;

    // glyph rows packed top row first, bit 4 of each row is the leftmost column
    function automatic logic [GLYPH_CELLS-1:0] glyph_bits(input logic [7:0] code);
        logic [GLYPH_CELLS-1:0] bits;
        case (code)
            8'h41: bits = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // A
            8'h42: bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E}; // B
            8'h43: bits = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E}; // C
            8'h44: bits = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E}; // D
            8'h45: bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F}; // E
            8'h46: bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10}; // F
            8'h47: bits = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E}; // G
            8'h48: bits = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // H
            8'h49: bits = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // I
            8'h4B: bits = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11}; // K
            8'h4C: bits = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F}; // L
            8'h4D: bits = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}; // M
            8'h4E: bits = {5'h11, 5'h19, 5'h19, 5'h15, 5'h13, 5'h13, 5'h11}; // N
            8'h4F: bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // O
            8'h50: bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10}; // P
            8'h52: bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11}; // R
            8'h53: bits = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E}; // S
            8'h54: bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // T
            8'h55: bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // U
            8'h56: bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04}; // V
            8'h59: bits = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04}; // Y
            8'h61: bits = {5'h00, 5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F}; // a
            8'h62: bits = {5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E}; // b
            8'h63: bits = {5'h00, 5'h00, 5'h0E, 5'h10, 5'h10, 5'h10, 5'h0E}; // c
            8'h64: bits = {5'h01, 5'h01, 5'h0D, 5'h13, 5'h11, 5'h11, 5'h0F}; // d
            8'h65: bits = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E}; // e
            8'h66: bits = {5'h06, 5'h08, 5'h08, 5'h1E, 5'h08, 5'h08, 5'h08}; // f
            8'h67: bits = {5'h00, 5'h00, 5'h0F, 5'h11, 5'h0F, 5'h01, 5'h0E}; // g
            8'h68: bits = {5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11}; // h
            8'h69: bits = {5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E}; // i
            8'h6B: bits = {5'h10, 5'h10, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12}; // k
            8'h6C: bits = {5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // l
            8'h6D: bits = {5'h00, 5'h00, 5'h1A, 5'h15, 5'h15, 5'h11, 5'h11}; // m
            8'h6E: bits = {5'h00, 5'h00, 5'h1A, 5'h15, 5'h11, 5'h11, 5'h11}; // n
            8'h6F: bits = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E}; // o
            8'h70: bits = {5'h00, 5'h00, 5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10}; // p
            8'h72: bits = {5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10}; // r
            8'h73: bits = {5'h00, 5'h00, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E}; // s
            8'h74: bits = {5'h08, 5'h08, 5'h1C, 5'h08, 5'h08, 5'h09, 5'h06}; // t
            8'h75: bits = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0D}; // u
            8'h76: bits = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04}; // v
            8'h77: bits = {5'h00, 5'h00, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0A}; // w
            8'h79: bits = {5'h00, 5'h00, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h0E}; // y
            8'h30: bits = {5'h0E, 5'h13, 5'h15, 5'h15, 5'h19, 5'h11, 5'h0E}; // 0
            8'h31: bits = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // 1
            8'h32: bits = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F}; // 2
            8'h33: bits = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E}; // 3
            8'h34: bits = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02}; // 4
            8'h35: bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E}; // 5
            8'h36: bits = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E}; // 6
            8'h37: bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}; // 7
            8'h38: bits = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E}; // 8
            8'h3A: bits = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}; // colon
            8'h2D: bits = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}; // minus
            8'h3E: bits = {5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10}; // greater
            8'h28: bits = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02}; // open paren
            8'h29: bits = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08}; // close paren
            default: bits = '0; // unmapped code, blank glyph
        endcase
        return bits;
    endfunction

endpackage

FILE: rtl/core/g5r_cell_walk.sv
module g5r_cell_walk #(
    parameter int SCREEN_WIDTH  = g5r_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = g5r_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  g5r_pkg::in_req_t    in_data,
    output g5r_pkg::walk_ctrl_t ctrl,
    output g5r_pkg::out_req_t   sq,
    input  logic                can_take
);

    localparam logic [16:0] SCR_W    = 17'(SCREEN_WIDTH);
    localparam logic [16:0] SCR_H    = 17'(SCREEN_HEIGHT);
    localparam logic [2:0]  LAST_COL = 3'(g5r_pkg::GLYPH_COLS - 1);
    localparam logic [2:0]  LAST_ROW = 3'(g5r_pkg::GLYPH_ROWS - 1);

    g5r_pkg::walk_state_t state_reg, state_next;

    logic [15:0] cursor_reg, cursor_next;
    logic [15:0] base_x_reg, base_x_next;
    logic [15:0] x_acc_reg, x_acc_next;
    logic [15:0] y_acc_reg, y_acc_next;
    logic [15:0] color_reg, color_next;
    logic [7:0]  scale_reg, scale_next;
    logic [7:0]  code_reg, code_next;
    logic [g5r_pkg::GLYPH_CELLS-1:0] bitmap_reg, bitmap_next;
    logic [2:0]  row_reg, row_next;
    logic [2:0]  col_reg, col_next;

    logic        accept;
    logic [15:0] load_x;
    logic [15:0] advance;
    logic [16:0] px_ext, py_ext, sum_x, sum_y;
    logic [15:0] step_sum;
    logic        visible;
    logic        step;
    logic        end_cell;

    assign accept = in_valid && in_ready;
    assign load_x = in_data.restart ? in_data.start_x : cursor_reg;
    // 6*scale as 4*scale + 2*scale
    assign advance = {6'd0, in_data.scale, 2'd0} + {7'd0, in_data.scale, 1'd0};

    // one adder steps x along a row, or y at the end of the row
    assign step_sum = ((col_reg == LAST_COL) ? y_acc_reg : x_acc_reg) + {8'd0, scale_reg};

    // clip check on the current cell
    assign px_ext  = {1'b0, x_acc_reg};
    assign py_ext  = {1'b0, y_acc_reg};
    assign sum_x   = px_ext + {9'd0, scale_reg};
    assign sum_y   = py_ext + {9'd0, scale_reg};
    assign visible = bitmap_reg[g5r_pkg::GLYPH_CELLS-1] && (scale_reg != 8'd0)
                     && (px_ext < SCR_W) && (py_ext < SCR_H);
    assign step     = !visible || can_take;
    assign end_cell = (row_reg == LAST_ROW) && (col_reg == LAST_COL);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            g5r_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = g5r_pkg::ST_LOOK;
                end
            end
            g5r_pkg::ST_LOOK:
            begin
                state_next = g5r_pkg::ST_WALK;
            end
            g5r_pkg::ST_WALK:
            begin
                if (step && end_cell)
                begin
                    state_next = g5r_pkg::ST_DONE;
                end
            end
            g5r_pkg::ST_DONE:
            begin
                if (can_take)
                begin
                    state_next = g5r_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = g5r_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        ctrl.sq_valid = 1'b0;
        ctrl.flush    = 1'b0;
        case (state_reg)
            g5r_pkg::ST_IDLE: in_ready      = 1'b1;
            g5r_pkg::ST_WALK: ctrl.sq_valid = visible;
            g5r_pkg::ST_DONE: ctrl.flush    = 1'b1;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        sq.rect_x     = x_acc_reg[8:0];
        sq.rect_y     = y_acc_reg[8:0];
        sq.rect_w     = (sum_x > SCR_W) ? 8'(SCR_W - px_ext) : scale_reg;
        sq.rect_h     = (sum_y > SCR_H) ? 8'(SCR_H - py_ext) : scale_reg;
        sq.rect_color = color_reg;
        sq.last       = 1'b0;
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        base_x_next = base_x_reg;
        x_acc_next  = x_acc_reg;
        y_acc_next  = y_acc_reg;
        color_next  = color_reg;
        scale_next  = scale_reg;
        code_next   = code_reg;
        bitmap_next = bitmap_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        if (accept)
        begin
            cursor_next = load_x + advance;
            base_x_next = load_x;
            x_acc_next  = load_x;
            y_acc_next  = in_data.row_y;
            color_next  = in_data.color;
            scale_next  = in_data.scale;
            code_next   = in_data.char_code;
        end
        if (state_reg == g5r_pkg::ST_LOOK)
        begin
            bitmap_next = g5r_pkg::glyph_bits(code_reg);
            row_next    = '0;
            col_next    = '0;
        end
        if ((state_reg == g5r_pkg::ST_WALK) && step)
        begin
            bitmap_next = {bitmap_reg[g5r_pkg::GLYPH_CELLS-2:0], 1'b0};
            if (col_reg == LAST_COL)
            begin
                col_next   = '0;
                row_next   = row_reg + 3'd1;
                x_acc_next = base_x_reg;
                y_acc_next = step_sum;
            end
            else
            begin
                col_next   = col_reg + 3'd1;
                x_acc_next = step_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= g5r_pkg::ST_IDLE;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_x_reg <= base_x_next;
        x_acc_reg  <= x_acc_next;
        y_acc_reg  <= y_acc_next;
        color_reg  <= color_next;
        scale_reg  <= scale_next;
        code_reg   <= code_next;
        bitmap_reg <= bitmap_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
    end

endmodule

FILE: rtl/core/g5r_emit.sv
module g5r_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  g5r_pkg::walk_ctrl_t ctrl,
    input  g5r_pkg::out_req_t   sq,
    output logic                can_take,
    output logic                out_valid,
    input  logic                out_ready,
    output g5r_pkg::out_req_t   out_data
);

    logic              pend_valid_reg, pend_valid_next;
    logic              out_valid_reg, out_valid_next;
    g5r_pkg::out_req_t pend_reg, pend_next;
    g5r_pkg::out_req_t out_reg, out_next;
    logic              out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign can_take  = !pend_valid_reg || out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // one square is held back until the next one or the end of the glyph
    // shows whether it is the last
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pend_next       = pend_reg;
        out_next        = out_reg;
        if (ctrl.sq_valid && can_take)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_next.last  = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = sq;
            pend_valid_next = 1'b1;
        end
        else if (ctrl.flush && can_take)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_next.last  = 1'b1;
                out_valid_next = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

FILE: rtl/core/glyph_5x7_rectangle_generator_top.sv
// Character to filled-square generator for a 5x7 font. Each request carries one
// character; restart loads the text cursor from start_x before drawing, and the
// cursor then moves right by 6*scale after the character (modulo 65536). After
// the glyph lookup, a sequencer walks the 35 glyph cells in row-major order,
// one cell per cycle while the output side keeps up, stepping x and y by scale
// through one shared adder and clipping each lit cell against SCREEN_WIDTH x
// SCREEN_HEIGHT. A new request is accepted only once the previous one has gone
// through accept, lookup, the 35 cells and the end-of-glyph flush; a visible
// square or the flush that finds the output side full holds the sequencer.
// Dropped squares (off screen or scale zero) are still walked like any other cell.
// One square is held back so the final square of a character leaves with last
// set; a character with no visible squares produces no output at all but still
// moves the cursor. A finished square waits in the output register without
// holding up the start of the next character.
module glyph_5x7_rectangle_generator_top #(
    parameter int SCREEN_WIDTH  = g5r_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = g5r_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  g5r_pkg::in_req_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output g5r_pkg::out_req_t out_data
);

    // walker to emitter: candidate square and end-of-glyph flush
    g5r_pkg::walk_ctrl_t ctrl;
    g5r_pkg::out_req_t   sq;
    // emitter can absorb a square or flush this cycle
    logic                can_take;

    g5r_cell_walk #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .ctrl     (ctrl),
        .sq       (sq),
        .can_take (can_take)
    );

    g5r_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sq        (sq),
        .can_take  (can_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/core/g5r_checker.sv
module g5r_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input g5r_pkg::out_req_t out_data
);

    // stalled square stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output square dropped or changed");

    // block is busy right after taking a character
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accepting a character");

    // clipped squares are never empty
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.rect_w != 8'd0) && (out_data.rect_h != 8'd0))
        else $error("empty square emitted");

    // a new character starts only once the previous one is closed, so a
    // square with last clear is followed by another square before ready
    a_last_before_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last |-> !in_ready)
        else $error("character ended without a last square");

endmodule

bind glyph_5x7_rectangle_generator_top g5r_checker u_g5r_checker (.*);

FILE: sim/square_checker.sv
`timescale 1ns / 100ps

module square_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  g5r_pkg::in_req_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  g5r_pkg::out_req_t out_data,
    output int                mismatches,
    output int                pending,
    output int                chars_seen,
    output int                squares_seen,
    output int                blank_chars
);

    localparam int SCR_W = g5r_pkg::SCREEN_WIDTH_DEF;
    localparam int SCR_H = g5r_pkg::SCREEN_HEIGHT_DEF;

    // one 5-bit row per glyph line, top line in the highest slot
    typedef logic [g5r_pkg::GLYPH_ROWS-1:0][g5r_pkg::GLYPH_COLS-1:0] glyph_t;

    g5r_pkg::out_req_t expected_squares[$];
    logic [15:0]       pen_x;
    int                fail_count   = 0;
    int                char_count   = 0;
    int                square_count = 0;
    int                blank_count  = 0;

    function automatic glyph_t font_rows(input logic [7:0] code);
        glyph_t g;
        case (code)
            "A": g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "B": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            "C": g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            "D": g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            "E": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "F": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            "G": g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
            "H": g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I": g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "K": g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            "M": g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            "N": g = {5'h11, 5'h19, 5'h19, 5'h15, 5'h13, 5'h13, 5'h11};
            "O": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "P": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            "R": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S": g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "T": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "V": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            "Y": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            "a": g = {5'h00, 5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F};
            "b": g = {5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
            "c": g = {5'h00, 5'h00, 5'h0E, 5'h10, 5'h10, 5'h10, 5'h0E};
            "d": g = {5'h01, 5'h01, 5'h0D, 5'h13, 5'h11, 5'h11, 5'h0F};
            "e": g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E};
            "f": g = {5'h06, 5'h08, 5'h08, 5'h1E, 5'h08, 5'h08, 5'h08};
            "g": g = {5'h00, 5'h00, 5'h0F, 5'h11, 5'h0F, 5'h01, 5'h0E};
            "h": g = {5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11};
            "i": g = {5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E};
            "k": g = {5'h10, 5'h10, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12};
            "l": g = {5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "m": g = {5'h00, 5'h00, 5'h1A, 5'h15, 5'h15, 5'h11, 5'h11};
            "n": g = {5'h00, 5'h00, 5'h1A, 5'h15, 5'h11, 5'h11, 5'h11};
            "o": g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
            "p": g = {5'h00, 5'h00, 5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10};
            "r": g = {5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10};
            "s": g = {5'h00, 5'h00, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E};
            "t": g = {5'h08, 5'h08, 5'h1C, 5'h08, 5'h08, 5'h09, 5'h06};
            "u": g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0D};
            "v": g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            "w": g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0A};
            "y": g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h0E};
            "0": g = {5'h0E, 5'h13, 5'h15, 5'h15, 5'h19, 5'h11, 5'h0E};
            "1": g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "2": g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            "3": g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "4": g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            "5": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            "6": g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            "7": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            "8": g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            ":": g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
            "-": g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            ">": g = {5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10};
            "(": g = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
            ")": g = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
            default: g = '0;
        endcase
        return g;
    endfunction

    // expand one character into its clipped squares, update the pen
    task automatic predict_squares(input g5r_pkg::in_req_t req);
        glyph_t            rows;
        int                px;
        int                py;
        int                w;
        int                h;
        int                s;
        int                made;
        g5r_pkg::out_req_t sq;
        g5r_pkg::out_req_t held;
        s    = int'(req.scale);
        made = 0;
        held = '0;
        if (req.restart)
            pen_x = req.start_x;
        rows = font_rows(req.char_code);
        for (int r = 0; r < g5r_pkg::GLYPH_ROWS; r++)
        begin
            for (int c = 0; c < g5r_pkg::GLYPH_COLS; c++)
            begin
                px = (int'(pen_x) + c * s) & 32'hFFFF;
                py = (int'(req.row_y) + r * s) & 32'hFFFF;
                if (rows[g5r_pkg::GLYPH_ROWS-1-r][g5r_pkg::GLYPH_COLS-1-c] && s != 0 &&
                    px < SCR_W && py < SCR_H)
                begin
                    w = (px + s > SCR_W) ? SCR_W - px : s;
                    h = (py + s > SCR_H) ? SCR_H - py : s;
                    sq.rect_x     = px[8:0];
                    sq.rect_y     = py[8:0];
                    sq.rect_w     = w[7:0];
                    sq.rect_h     = h[7:0];
                    sq.rect_color = req.color;
                    sq.last       = 1'b0;
                    // hold one back so the final one can carry last
                    if (made > 0)
                        expected_squares.push_back(held);
                    held = sq;
                    made++;
                end
            end
        end
        if (made > 0)
        begin
            held.last = 1'b1;
            expected_squares.push_back(held);
        end
        else
            blank_count++;
        pen_x = 16'(int'(pen_x) + g5r_pkg::ADVANCE_CELLS * s);
    endtask

    task automatic check_square(input g5r_pkg::out_req_t got);
        g5r_pkg::out_req_t want;
        square_count++;
        if (expected_squares.size() == 0)
        begin
            fail_count++;
            $display("%0t: square mismatch, expected no square", $time);
            $display("%0t:   actual x=%0d y=%0d w=%0d h=%0d %s",
                     $time, got.rect_x, got.rect_y, got.rect_w, got.rect_h,
                     $sformatf("color=%h last=%0d", got.rect_color, got.last));
        end
        else
        begin
            want = expected_squares.pop_front();
            if (got !== want)
            begin
                fail_count++;
                $display("%0t: square mismatch, expected x=%0d y=%0d w=%0d h=%0d %s",
                         $time, want.rect_x, want.rect_y, want.rect_w, want.rect_h,
                         $sformatf("color=%h last=%0d", want.rect_color, want.last));
                $display("%0t:                  actual x=%0d y=%0d w=%0d h=%0d %s",
                         $time, got.rect_x, got.rect_y, got.rect_w, got.rect_h,
                         $sformatf("color=%h last=%0d", got.rect_color, got.last));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            pen_x = '0;
        else
        begin
            if (in_valid && in_ready)
            begin
                char_count++;
                predict_squares(in_data);
            end
            if (out_valid && out_ready)
                check_square(out_data);
        end
        mismatches   <= fail_count;
        pending      <= expected_squares.size();
        chars_seen   <= char_count;
        squares_seen <= square_count;
        blank_chars  <= blank_count;
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;

    // stimulus size and pacing
    localparam int ITEMS        = 260;
    localparam int HOLD_AT      = 40;    // requests sent before the long output hold-off
    localparam int HOLD_CYCLES  = 400;   // length of that hold-off
    localparam int DRAIN_CYCLES = 60;    // longer than one character time
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all before giving up

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    g5r_pkg::in_req_t  in_data;
    logic              out_valid;
    logic              out_ready;
    g5r_pkg::out_req_t out_data;

    int mismatches;
    int pending;
    int chars_seen;
    int squares_seen;
    int blank_chars;

    int    n_sent       = 0;
    int    idle_pct     = 0;
    bit    hold_done    = 1'b0;
    int    quiet_cycles = 0;
    string glyph_codes;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    glyph_5x7_rectangle_generator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // predicts every square from the accepted requests and compares
    square_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .chars_seen   (chars_seen),
        .squares_seen (squares_seen),
        .blank_chars  (blank_chars)
    );

    // idle length: mostly short, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return $urandom_range(1, 3);
        else if (roll < 9)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic g5r_pkg::in_req_t make_req(input logic [7:0] code, input logic rs,
                                                  input logic [15:0] sx, input logic [15:0] ry,
                                                  input logic [15:0] col,
                                                  input logic [7:0] scl);
        g5r_pkg::in_req_t r;
        r.char_code = code;
        r.restart   = rs;
        r.start_x   = sx;
        r.row_y     = ry;
        r.color     = col;
        r.scale     = scl;
        return r;
    endfunction

    // cell size for a random string: mostly small, some medium, a few anything
    function automatic logic [7:0] pick_scale();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return 8'($urandom_range(1, 4));
        else if (roll < 9)
            return 8'($urandom_range(5, 20));
        return 8'($urandom_range(0, 255));
    endfunction

    // offer one request, optionally after an idle gap, and wait for the handshake
    task automatic send_char(input g5r_pkg::in_req_t req);
        int gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = pick_gap();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= req;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        n_sent++;
    endtask

    // a well-formed string: restart on the first character, then plain followers
    task automatic send_string(input int len);
        logic [7:0]  scl;
        logic [15:0] sx;
        logic [15:0] ry;
        logic [15:0] col;
        logic [7:0]  code;
        scl = pick_scale();
        sx  = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 319))
                                          : 16'($urandom_range(0, 65535));
        ry  = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 479))
                                          : 16'($urandom_range(0, 65535));
        col = 16'($urandom_range(0, 65535));
        for (int k = 0; k < len; k++)
        begin
            code = glyph_codes[$urandom_range(0, glyph_codes.len() - 1)];
            // start_x on followers is ignored by the block, so it is pure noise
            send_char(make_req(code, k == 0, (k == 0) ? sx : 16'($urandom_range(0, 65535)),
                               ry, col, scl));
        end
    endtask

    // output side: random stalls, one long hold-off so the block backs up
    initial
    begin
        int stall;
        int run;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = 0;
            if (!hold_done && n_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                stall     = HOLD_CYCLES;
            end
            else if ($urandom_range(0, 99) < 35)
                stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            // some long stretches with the output always ready
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
        end
    end

    // watchdog: no handshake on either side for too long means the block hung
    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
            quiet_cycles <= quiet_cycles + 1;
        else
            quiet_cycles <= 0;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no handshake for %0d cycles, %0d squares outstanding",
                     $time, quiet_cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] sx;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        glyph_codes = "ABCDEFGHIKLMNOPRSTUVYabcdefghiklmnoprstuvwy012345678:->()";

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling on the input side
        idle_pct = 0;
        // unit scale at the origin, full color
        send_char(make_req("A", 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 8'd1));
        // largest scale continuing the cursor, heavy clipping
        send_char(make_req("H", 1'b0, 16'hFFFF, 16'h0000, 16'h0000, 8'd255));
        // unmapped codes, low and high, still move the cursor
        send_char(make_req(8'h00, 1'b0, 16'h0000, 16'd100, 16'h1234, 8'd3));
        send_char(make_req(8'hFF, 1'b1, 16'h0000, 16'd100, 16'hFFFF, 8'd3));
        send_char(make_req(8'h80, 1'b0, 16'h0000, 16'd100, 16'h0001, 8'd3));
        // zero scale draws nothing and leaves the cursor where it was
        send_char(make_req("M", 1'b1, 16'd50, 16'd50, 16'hF800, 8'd0));
        send_char(make_req("B", 1'b0, 16'h0000, 16'd50, 16'h07E0, 8'd4));
        // bottom right corner, one pixel survives
        send_char(make_req("E", 1'b1, 16'd319, 16'd479, 16'h001F, 8'd4));
        // wholly off screen to the right and below
        send_char(make_req("8", 1'b1, 16'd320, 16'h0000, 16'hAAAA, 8'd2));
        send_char(make_req("O", 1'b1, 16'h0000, 16'd480, 16'h5555, 8'd2));
        // x and y wrapping past 65535 back onto the screen; W is unmapped and draws nothing
        send_char(make_req("0", 1'b1, 16'hFFFF, 16'd10, 16'h8001, 8'd2));
        send_char(make_req("T", 1'b1, 16'd10, 16'hFFFE, 16'h7FFE, 8'd3));
        send_char(make_req("W", 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255));
        // partial clipping on both edges
        send_char(make_req("8", 1'b1, 16'd300, 16'd460, 16'hC0DE, 8'd8));
        // huge cell at the origin plus one clipped to both edges
        send_char(make_req(">", 1'b1, 16'h0000, 16'h0000, 16'hAAAA, 8'd255));
        send_char(make_req("-", 1'b0, 16'h0000, 16'h0000, 16'h5555, 8'd1));
        send_char(make_req(":", 1'b1, 16'd160, 16'd240, 16'h0F0F, 8'd1));
        send_char(make_req("m", 1'b0, 16'h0000, 16'd240, 16'hF0F0, 8'd2));
        send_char(make_req("y", 1'b0, 16'h0000, 16'd240, 16'h3C3C, 8'd2));
        send_char(make_req(")", 1'b0, 16'h0000, 16'd240, 16'hC3C3, 8'd2));

        // every glyph in the font once, with line breaks now and then
        idle_pct = 30;
        sx = 16'($urandom_range(0, 300));
        for (int k = 0; k < glyph_codes.len(); k++)
            send_char(make_req(glyph_codes[k], (k == 0) || ($urandom_range(0, 99) < 15),
                               (k == 0) ? sx : 16'($urandom_range(0, 319)),
                               16'($urandom_range(0, 470)), 16'($urandom_range(0, 65535)),
                               8'($urandom_range(1, 3))));

        // random strings with some fully random requests mixed in
        while (n_sent < ITEMS)
        begin
            idle_pct = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(10, 60);
            if ($urandom_range(0, 4) == 0)
                send_char(make_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                   16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)),
                                   8'($urandom_range(0, 255))));
            else
                send_string($urandom_range(2, 12));
        end
        in_valid <= 1'b0;

        // let the last accepted request reach the checker, then drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d characters (%0d with nothing on screen) and %0d squares",
                 chars_seen, blank_chars, squares_seen);
        $display("including one %0d-cycle output hold-off with requests still offered",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
